// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/agcm_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128-GCM package
// Types, codes and AES helper functions shared by the stream core.
// ----------------------------------------------------------------------------
package agcm_pkg;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_HIGH     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_LOW      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NONCE_HIGH   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NONCE_LOW    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DECRYPT_MODE = 3'd4;

   typedef enum logic [1:0] {
      REQ_AAD    = 2'd0,
      REQ_TEXT   = 2'd1,
      REQ_FINISH = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      PHASE_FRESH = 2'd0,
      PHASE_AAD   = 2'd1,
      PHASE_TEXT  = 2'd2
   } msg_phase_type;

   typedef enum logic [1:0] {
      AES_SRC_ZERO = 2'd0,
      AES_SRC_J0   = 2'd1,
      AES_SRC_CTR  = 2'd2
   } aes_src_type;

   typedef enum logic [1:0] {
      GF_SRC_AAD  = 2'd0,
      GF_SRC_TEXT = 2'd1,
      GF_SRC_LEN  = 2'd2
   } gf_src_type;

   typedef enum logic [1:0] {
      OUT_ORDER = 2'd0,
      OUT_TEXT  = 2'd1,
      OUT_FINAL = 2'd2
   } out_kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_HKEY,
      S_J0,
      S_DISPATCH,
      S_CTR,
      S_GF_AAD,
      S_GF_TEXT,
      S_GF_LEN,
      S_EMIT_TEXT,
      S_EMIT_FINAL,
      S_EMIT_ORDER
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load_req;
      logic         aes_start;
      logic         aes_expand;
      aes_src_type  aes_src;
      logic         save_h;
      logic         save_j0;
      logic         init_msg;
      logic         gf_start;
      gf_src_type   gf_src;
      logic         aad_commit;
      logic         text_commit;
      logic         out_load;
      out_kind_type out_kind;
   } agcm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic         aes_done;
      logic         gf_done;
      req_kind_type req_kind;
      logic         count_zero;
   } agcm_status_type;

   localparam logic [7:0] SBOX [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // Multiply by x in GF(2^8).
   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // Round constant for the given round, one to ten.
   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] v;
      case (r)
         4'd1:    v = 8'h01;
         4'd2:    v = 8'h02;
         4'd3:    v = 8'h04;
         4'd4:    v = 8'h08;
         4'd5:    v = 8'h10;
         4'd6:    v = 8'h20;
         4'd7:    v = 8'h40;
         4'd8:    v = 8'h80;
         4'd9:    v = 8'h1b;
         4'd10:   v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   // One AES round without the key addition; the last round skips MixColumns.
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [7:0]   sb [16];
      logic [7:0]   t  [16];
      logic [7:0]   m  [16];
      logic [127:0] r;
      for (int i = 0; i < 16; i++) begin
         sb[i] = s[127-8*i -: 8];
      end
      for (int i = 0; i < 16; i++) begin
         t[i] = SBOX[sb[(i + 4*(i & 3)) & 15]];
      end
      for (int c = 0; c < 16; c += 4) begin
         m[c]   = xtime(t[c]) ^ xtime(t[c+1]) ^ t[c+1] ^ t[c+2] ^ t[c+3];
         m[c+1] = t[c] ^ xtime(t[c+1]) ^ xtime(t[c+2]) ^ t[c+2] ^ t[c+3];
         m[c+2] = t[c] ^ t[c+1] ^ xtime(t[c+2]) ^ xtime(t[c+3]) ^ t[c+3];
         m[c+3] = xtime(t[c]) ^ t[c] ^ t[c+1] ^ t[c+2] ^ xtime(t[c+3]);
      end
      for (int i = 0; i < 16; i++) begin
         r[127-8*i -: 8] = last ? t[i] : m[i];
      end
      return r;
   endfunction

   // Next AES-128 round key from the previous one.
   function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] t;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
      t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
      w0 = k[127:96] ^ t;
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      w3 = k[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // Mask with the leading n bytes of a block set.
   function automatic logic [127:0] byte_mask(input logic [4:0] n);
      logic [127:0] m;
      for (int i = 0; i < 16; i++) begin
         m[127-8*i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
      end
      return m;
   endfunction

endpackage

// ===== src/agcm_channels.sv =====
// ----------------------------------------------------------------------------
// AES-128-GCM channels
// Valid/ready interfaces for the request and response item streams.
// ----------------------------------------------------------------------------
interface agcm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [63:0] block_high;
   logic [63:0] block_low;
   logic [4:0]  byte_count;

   modport source (output valid, req_type, block_high, block_low, byte_count, input ready);
   modport sink   (input valid, req_type, block_high, block_low, byte_count, output ready);
endinterface

interface agcm_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_high;
   logic [63:0] out_low;
   logic [4:0]  out_count;
   logic        is_final;
   logic        tag_match;
   logic        order_error;

   modport source (output valid, out_high, out_low, out_count, is_final, tag_match,
                   order_error, input ready);
   modport sink   (input valid, out_high, out_low, out_count, is_final, tag_match,
                   order_error, output ready);
endinterface

// ===== src/agcm_aes_core.sv =====
// ----------------------------------------------------------------------------
// AES-128 round engine
// One round per cycle; expands the key on the fly or replays the stored keys.
// ----------------------------------------------------------------------------
module agcm_aes_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         expand,
   input  logic [127:0] block_in,
   input  logic [127:0] key_in,
   output logic [127:0] result,
   output logic         done
);

   logic [127:0] state_ff;
   logic [127:0] state_in;
   logic [127:0] rk_ff;
   logic [127:0] rk_in;
   logic [3:0]   round_ff;
   logic [3:0]   round_in;
   logic         busy_ff;
   logic         busy_in;
   logic         expand_ff;
   logic         expand_in;
   logic         done_ff;
   logic         done_in;
   logic [127:0] rk_file [1:10];
   logic [127:0] key0_ff;
   logic [127:0] rk_rd_ff;
   logic [3:0]   rd_addr;
   logic [127:0] rk_next;
   logic [127:0] key0;

   // Round key file read is registered: the key of the next round is
   // fetched ahead so that it is ready when that round runs.
   assign rd_addr = start ? 4'd1 : ((round_ff == 4'd10) ? 4'd10 : round_ff + 4'd1);
   assign key0    = expand ? key_in : key0_ff;
   assign rk_next = expand_ff ? agcm_pkg::key_next(rk_ff, agcm_pkg::rcon(round_ff))
                              : rk_rd_ff;

   // Round sequencing.
   always_comb begin
      state_in  = state_ff;
      rk_in     = rk_ff;
      round_in  = round_ff;
      busy_in   = busy_ff;
      expand_in = expand_ff;
      done_in   = 1'b0;
      if (start) begin
         state_in  = block_in ^ key0;
         rk_in     = key0;
         round_in  = 4'd1;
         busy_in   = 1'b1;
         expand_in = expand;
      end else if (busy_ff) begin
         state_in = agcm_pkg::aes_round(state_ff, round_ff == 4'd10) ^ rk_next;
         rk_in    = rk_next;
         round_in = round_ff + 4'd1;
         if (round_ff == 4'd10) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers and round key file.
   always_ff @(posedge clock) begin
      state_ff  <= state_in;
      rk_ff     <= rk_in;
      round_ff  <= round_in;
      expand_ff <= expand_in;
      rk_rd_ff  <= rk_file[rd_addr];
      if (start && expand) begin
         key0_ff <= key_in;
      end else if (busy_ff && expand_ff) begin
         rk_file[round_ff] <= rk_next;
      end
   end

   assign result = state_ff;
   assign done   = done_ff;

endmodule

// ===== src/agcm_ghash.sv =====
// ----------------------------------------------------------------------------
// GHASH multiplier
// GF(2^128) multiply by the hash subkey, eight bits of the operand a cycle.
// ----------------------------------------------------------------------------
module agcm_ghash (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] x_in,
   input  logic [127:0] h_in,
   output logic [127:0] z_out,
   output logic         done
);

   logic [127:0] x_ff;
   logic [127:0] x_in_next;
   logic [127:0] v_ff;
   logic [127:0] v_in;
   logic [127:0] z_ff;
   logic [127:0] z_in;
   logic [3:0]   step_ff;
   logic [3:0]   step_in;
   logic         busy_ff;
   logic         busy_in;
   logic         done_ff;
   logic         done_in;

   // Eight shift-and-add steps per cycle, most significant bit first.
   always_comb begin
      logic [127:0] v;
      logic [127:0] z;
      v         = v_ff;
      z         = z_ff;
      x_in_next = x_ff;
      v_in      = v_ff;
      z_in      = z_ff;
      step_in   = step_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         x_in_next = x_in;
         v_in      = h_in;
         z_in      = '0;
         step_in   = 4'd0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         for (int j = 0; j < 8; j++) begin
            if (x_ff[127-j]) begin
               z = z ^ v;
            end
            v = {1'b0, v[127:1]} ^ (v[0] ? {8'he1, 120'b0} : 128'b0);
         end
         x_in_next = {x_ff[119:0], 8'b0};
         v_in      = v;
         z_in      = z;
         step_in   = step_ff + 4'd1;
         if (step_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Operand registers.
   always_ff @(posedge clock) begin
      x_ff    <= x_in_next;
      v_ff    <= v_in;
      z_ff    <= z_in;
      step_ff <= step_in;
   end

   assign z_out = z_ff;
   assign done  = done_ff;

endmodule

// ===== src/agcm_datapath.sv =====
// ----------------------------------------------------------------------------
// AES-128-GCM datapath
// Configuration, message state, AES and GHASH units and the result register.
// ----------------------------------------------------------------------------
module agcm_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  agcm_pkg::agcm_cmd_type                 cmd,
   output agcm_pkg::agcm_status_type              status,
   input  logic [1:0]                             req_type,
   input  logic [63:0]                            block_high,
   input  logic [63:0]                            block_low,
   input  logic [4:0]                             byte_count,
   input  logic                                   csr_we,
   input  logic [agcm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [63:0]                            csr_wdata,
   output logic [63:0]                            out_high,
   output logic [63:0]                            out_low,
   output logic [4:0]                             out_count,
   output logic                                   is_final,
   output logic                                   tag_match,
   output logic                                   order_error
);

   // Configuration registers.
   logic [63:0] key_high_ff;
   logic [63:0] key_low_ff;
   logic [63:0] nonce_high_ff;
   logic [31:0] nonce_low_ff;
   logic        decrypt_mode_ff;

   // Latched item.
   agcm_pkg::req_kind_type kind_ff;
   logic [127:0]           blk_ff;
   logic [4:0]             count_ff;
   logic [4:0]             count_sat;

   // Message state.
   logic [127:0] h_ff;
   logic [127:0] j0_ff;
   logic [127:0] acc_ff;
   logic [31:0]  ctr_ff;
   logic [28:0]  aad_bytes_ff;
   logic [28:0]  text_bytes_ff;

   // Result register.
   logic [63:0] out_high_ff;
   logic [63:0] out_low_ff;
   logic [4:0]  out_count_ff;
   logic        is_final_ff;
   logic        tag_match_ff;
   logic        order_error_ff;

   logic [127:0] mask;
   logic [127:0] text_in;
   logic [127:0] text_out;
   logic [127:0] tag;
   logic [127:0] aes_block;
   logic [127:0] aes_result;
   logic         aes_done;
   logic [127:0] gf_block;
   logic [127:0] gf_result;
   logic         gf_done;

   // Configuration writes; indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff     <= '0;
         key_low_ff      <= '0;
         nonce_high_ff   <= '0;
         nonce_low_ff    <= '0;
         decrypt_mode_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            agcm_pkg::CSR_KEY_HIGH:     key_high_ff     <= csr_wdata;
            agcm_pkg::CSR_KEY_LOW:      key_low_ff      <= csr_wdata;
            agcm_pkg::CSR_NONCE_HIGH:   nonce_high_ff   <= csr_wdata;
            agcm_pkg::CSR_NONCE_LOW:    nonce_low_ff    <= csr_wdata[31:0];
            agcm_pkg::CSR_DECRYPT_MODE: decrypt_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Byte counts above sixteen saturate.
   assign count_sat = (byte_count > 5'd16) ? 5'd16 : byte_count;

   // Text masking and the counter-mode XOR.
   assign mask     = agcm_pkg::byte_mask(count_ff);
   assign text_in  = blk_ff & mask;
   assign text_out = (text_in ^ aes_result) & mask;
   assign tag      = acc_ff ^ j0_ff;

   // AES input block.
   always_comb begin
      case (cmd.aes_src)
         agcm_pkg::AES_SRC_J0:  aes_block = {nonce_high_ff, nonce_low_ff, 32'd1};
         agcm_pkg::AES_SRC_CTR: aes_block = {nonce_high_ff, nonce_low_ff, ctr_ff};
         default:               aes_block = '0;
      endcase
   end

   // GHASH input block, folded into the accumulator.
   always_comb begin
      case (cmd.gf_src)
         agcm_pkg::GF_SRC_AAD:  gf_block = text_in;
         agcm_pkg::GF_SRC_TEXT: gf_block = decrypt_mode_ff ? text_in : text_out;
         default: gf_block = {32'b0, aad_bytes_ff, 3'b0, 32'b0, text_bytes_ff, 3'b0};
      endcase
   end

   agcm_aes_core u_aes (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.aes_start),
      .expand   (cmd.aes_expand),
      .block_in (aes_block),
      .key_in   ({key_high_ff, key_low_ff}),
      .result   (aes_result),
      .done     (aes_done)
   );

   agcm_ghash u_ghash (
      .clock (clock),
      .reset (reset),
      .start (cmd.gf_start),
      .x_in  (acc_ff ^ gf_block),
      .h_in  (h_ff),
      .z_out (gf_result),
      .done  (gf_done)
   );

   // Item latch and message state.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff  <= agcm_pkg::req_kind_type'(req_type);
         blk_ff   <= {block_high, block_low};
         count_ff <= count_sat;
      end
      if (cmd.save_h) begin
         h_ff <= aes_result;
      end
      if (cmd.save_j0) begin
         j0_ff <= aes_result;
      end
      if (cmd.init_msg) begin
         acc_ff        <= '0;
         ctr_ff        <= 32'd2;
         aad_bytes_ff  <= '0;
         text_bytes_ff <= '0;
      end else begin
         if (gf_done) begin
            acc_ff <= gf_result;
         end
         if (cmd.aad_commit) begin
            aad_bytes_ff <= aad_bytes_ff + 29'(count_ff);
         end
         if (cmd.text_commit) begin
            text_bytes_ff <= text_bytes_ff + 29'(count_ff);
            ctr_ff        <= ctr_ff + 32'd1;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_high_ff    <= '0;
         out_low_ff     <= '0;
         out_count_ff   <= '0;
         is_final_ff    <= 1'b0;
         tag_match_ff   <= 1'b0;
         order_error_ff <= 1'b0;
         case (cmd.out_kind)
            agcm_pkg::OUT_TEXT: begin
               {out_high_ff, out_low_ff} <= text_out;
               out_count_ff              <= count_ff;
            end
            agcm_pkg::OUT_FINAL: begin
               is_final_ff <= 1'b1;
               if (decrypt_mode_ff) begin
                  tag_match_ff <= (tag == blk_ff);
               end else begin
                  {out_high_ff, out_low_ff} <= tag;
                  out_count_ff              <= 5'd16;
               end
            end
            default: order_error_ff <= 1'b1;
         endcase
      end
   end

   assign status.aes_done   = aes_done;
   assign status.gf_done    = gf_done;
   assign status.req_kind   = kind_ff;
   assign status.count_zero = (count_ff == 5'd0);

   assign out_high    = out_high_ff;
   assign out_low     = out_low_ff;
   assign out_count   = out_count_ff;
   assign is_final    = is_final_ff;
   assign tag_match   = tag_match_ff;
   assign order_error = order_error_ff;

endmodule

// ===== src/agcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// AES-128-GCM controller
// Sequences message setup, AAD, text and finish items over the datapath.
// ----------------------------------------------------------------------------
module agcm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  agcm_pkg::agcm_status_type status,
   output agcm_pkg::agcm_cmd_type    cmd
);

   agcm_pkg::ctrl_state_type state_ff;
   agcm_pkg::ctrl_state_type state_in;
   agcm_pkg::msg_phase_type  phase_ff;
   agcm_pkg::msg_phase_type  phase_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     out_free;

   // The result slot is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         agcm_pkg::S_IDLE: begin
            if (req_valid) state_in = agcm_pkg::S_DECODE;
         end
         agcm_pkg::S_DECODE: begin
            if (status.req_kind == agcm_pkg::REQ_NONE) begin
               state_in = agcm_pkg::S_IDLE;
            end else if (status.req_kind == agcm_pkg::REQ_AAD &&
                         phase_ff == agcm_pkg::PHASE_TEXT) begin
               state_in = agcm_pkg::S_EMIT_ORDER;
            end else if (phase_ff == agcm_pkg::PHASE_FRESH) begin
               state_in = agcm_pkg::S_HKEY;
            end else begin
               state_in = agcm_pkg::S_DISPATCH;
            end
         end
         agcm_pkg::S_HKEY: begin
            if (status.aes_done) state_in = agcm_pkg::S_J0;
         end
         agcm_pkg::S_J0: begin
            if (status.aes_done) state_in = agcm_pkg::S_DISPATCH;
         end
         agcm_pkg::S_DISPATCH: begin
            case (status.req_kind)
               agcm_pkg::REQ_AAD:
                  state_in = status.count_zero ? agcm_pkg::S_IDLE : agcm_pkg::S_GF_AAD;
               agcm_pkg::REQ_TEXT:
                  state_in = status.count_zero ? agcm_pkg::S_EMIT_TEXT : agcm_pkg::S_CTR;
               default:
                  state_in = agcm_pkg::S_GF_LEN;
            endcase
         end
         agcm_pkg::S_CTR: begin
            if (status.aes_done) state_in = agcm_pkg::S_GF_TEXT;
         end
         agcm_pkg::S_GF_AAD: begin
            if (status.gf_done) state_in = agcm_pkg::S_IDLE;
         end
         agcm_pkg::S_GF_TEXT: begin
            if (status.gf_done) state_in = agcm_pkg::S_EMIT_TEXT;
         end
         agcm_pkg::S_GF_LEN: begin
            if (status.gf_done) state_in = agcm_pkg::S_EMIT_FINAL;
         end
         agcm_pkg::S_EMIT_TEXT, agcm_pkg::S_EMIT_FINAL, agcm_pkg::S_EMIT_ORDER: begin
            if (out_free) state_in = agcm_pkg::S_IDLE;
         end
         default: state_in = agcm_pkg::S_IDLE;
      endcase
   end

   // Commands, message phase and result valid.
   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         agcm_pkg::S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         agcm_pkg::S_DECODE: begin
            if (status.req_kind != agcm_pkg::REQ_NONE &&
                phase_ff == agcm_pkg::PHASE_FRESH) begin
               cmd.aes_start  = 1'b1;
               cmd.aes_expand = 1'b1;
               cmd.aes_src    = agcm_pkg::AES_SRC_ZERO;
            end
         end
         agcm_pkg::S_HKEY: begin
            if (status.aes_done) begin
               cmd.save_h    = 1'b1;
               cmd.aes_start = 1'b1;
               cmd.aes_src   = agcm_pkg::AES_SRC_J0;
            end
         end
         agcm_pkg::S_J0: begin
            if (status.aes_done) begin
               cmd.save_j0  = 1'b1;
               cmd.init_msg = 1'b1;
               phase_in     = agcm_pkg::PHASE_AAD;
            end
         end
         agcm_pkg::S_DISPATCH: begin
            case (status.req_kind)
               agcm_pkg::REQ_AAD: begin
                  cmd.gf_start = !status.count_zero;
                  cmd.gf_src   = agcm_pkg::GF_SRC_AAD;
               end
               agcm_pkg::REQ_TEXT: begin
                  phase_in      = agcm_pkg::PHASE_TEXT;
                  cmd.aes_start = !status.count_zero;
                  cmd.aes_src   = agcm_pkg::AES_SRC_CTR;
               end
               default: begin
                  cmd.gf_start = 1'b1;
                  cmd.gf_src   = agcm_pkg::GF_SRC_LEN;
               end
            endcase
         end
         agcm_pkg::S_CTR: begin
            if (status.aes_done) begin
               cmd.gf_start = 1'b1;
               cmd.gf_src   = agcm_pkg::GF_SRC_TEXT;
            end
         end
         agcm_pkg::S_GF_AAD: begin
            cmd.aad_commit = status.gf_done;
         end
         agcm_pkg::S_GF_TEXT: begin
            cmd.text_commit = status.gf_done;
         end
         agcm_pkg::S_GF_LEN: begin
            if (status.gf_done) phase_in = agcm_pkg::PHASE_FRESH;
         end
         agcm_pkg::S_EMIT_TEXT: begin
            cmd.out_kind = agcm_pkg::OUT_TEXT;
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         agcm_pkg::S_EMIT_FINAL: begin
            cmd.out_kind = agcm_pkg::OUT_FINAL;
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         agcm_pkg::S_EMIT_ORDER: begin
            cmd.out_kind = agcm_pkg::OUT_ORDER;
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= agcm_pkg::S_IDLE;
         phase_ff     <= agcm_pkg::PHASE_FRESH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/aes128_gcm_stream_core.sv =====
// ----------------------------------------------------------------------------
// AES-128-GCM stream core
// Authenticated encryption and decryption of AAD and text items, 96-bit IV.
// ----------------------------------------------------------------------------
// One item is processed at a time; a finished result waits in the output
// register while the next item is taken. A single AES round unit runs one
// round a cycle and the GHASH multiplier folds eight bits a cycle, one after
// the other. The first item of each message also expands the key and
// derives H and E(J0). On decrypt, plaintext is returned before the tag is
// checked: the consumer must drop it when the finish item reports a mismatch.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aes128_gcm_stream_core (
   input  logic                                 clock,
   input  logic                                 reset,
   agcm_req_if.sink                             req_chan,
   agcm_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [agcm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [63:0]                          csr_wdata
);

   agcm_pkg::agcm_cmd_type    cmd;
   agcm_pkg::agcm_status_type status;

   // Sequencer.
   agcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Cipher and hash datapath.
   agcm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_type    (req_chan.req_type),
      .block_high  (req_chan.block_high),
      .block_low   (req_chan.block_low),
      .byte_count  (req_chan.byte_count),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .out_high    (rsp_chan.out_high),
      .out_low     (rsp_chan.out_low),
      .out_count   (rsp_chan.out_count),
      .is_final    (rsp_chan.is_final),
      .tag_match   (rsp_chan.tag_match),
      .order_error (rsp_chan.order_error)
   );

   // Items are taken one at a time.
   `ASSERT_NEXT(a_one_item, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "item accepted while another is in progress")

   // A finish result carries a full tag or no data.
   `ASSERT_IMPLIES(a_final_count, clock, reset, rsp_chan.valid && rsp_chan.is_final, rsp_chan.out_count == 5'd16 || rsp_chan.out_count == 5'd0, "finish result with a partial count")

   // An ordering error carries nothing else.
   `ASSERT_IMPLIES(a_order_clean, clock, reset, rsp_chan.valid && rsp_chan.order_error, rsp_chan.out_count == 5'd0 && !rsp_chan.is_final && !rsp_chan.tag_match, "ordering error result carries data")

   // A tag verdict only comes with a decrypt finish result.
   `ASSERT_IMPLIES(a_match_final, clock, reset, rsp_chan.valid && rsp_chan.tag_match, rsp_chan.is_final && rsp_chan.out_count == 5'd0, "tag match outside a decrypt finish")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// AES-128-GCM stream core testbench
// Drives AAD, text and finish items through the core under random idling on
// both channels and checks every response against a behavioural AES-GCM
// model kept here. A short table of directed items opens the run and is
// followed by random messages. The key, IV and mode change only between
// messages.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int ITEM_TARGET = 1800;
   localparam int SETTLE_CYCLES = 120;

   typedef struct packed {
      logic [63:0] out_high;
      logic [63:0] out_low;
      logic [4:0]  out_count;
      logic        is_final;
      logic        tag_match;
      logic        order_error;
   } gcm_result_type;

   // One row of the directed table.
   typedef struct {
      agcm_pkg::req_kind_type kind;
      logic [63:0]            block_high;
      logic [63:0]            block_low;
      logic [4:0]             byte_count;
      bit                     set_decrypt;
      bit                     good_tag;
      bit                     typed;
      gcm_result_type         typed_result;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [agcm_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [63:0] csr_wdata;

   agcm_req_if req_chan ();
   agcm_rsp_if rsp_chan ();

   aes128_gcm_stream_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Model state and configuration.
   logic [7:0]              sub_table [256];
   logic [127:0]            cipher_key;
   logic [63:0]             iv_high;
   logic [31:0]             iv_low;
   logic                    decrypt_on;
   logic [127:0]            sched_key [11];
   logic [127:0]            hash_key;
   logic [127:0]            tag_mask;
   logic [127:0]            hash_acc;
   logic [31:0]             counter;
   logic [28:0]             aad_total;
   logic [28:0]             text_total;
   agcm_pkg::msg_phase_type phase;

   gcm_result_type pending_results [$];
   int  error_count;
   int  cycle_count;
   int  items_sent;
   int  results_seen;
   bit  quiet_sender;
   bit  quiet_receiver;

   always #5 clock = ~clock;

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Multiplication in GF(2^8) with the AES polynomial.
   function automatic logic [7:0] byte_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return p;
   endfunction

   // S-box built from the multiplicative inverse and the affine map.
   function automatic void build_sub_table();
      logic [7:0] inv;
      logic [7:0] sq;
      for (int x = 0; x < 256; x++) begin
         // x^254 is the inverse, and zero maps to zero.
         inv = 8'h01;
         sq = 8'(x);
         for (int e = 0; e < 8; e++) begin
            if ((254 >> e) & 1) inv = byte_mul(inv, sq);
            sq = byte_mul(sq, sq);
         end
         if (x == 0) inv = 8'h00;
         sub_table[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      end
   endfunction

   function automatic logic [7:0] dbl8(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic void expand_cipher_key();
      logic [7:0]  rc;
      logic [31:0] t;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
      logic [127:0] k;
      rc = 8'h01;
      k = cipher_key;
      sched_key[0] = k;
      for (int r = 1; r <= 10; r++) begin
         t = {sub_table[k[23:16]] ^ rc, sub_table[k[15:8]], sub_table[k[7:0]],
              sub_table[k[31:24]]};
         w0 = k[127:96] ^ t;
         w1 = k[95:64] ^ w0;
         w2 = k[63:32] ^ w1;
         w3 = k[31:0] ^ w2;
         k = {w0, w1, w2, w3};
         sched_key[r] = k;
         rc = dbl8(rc);
      end
   endfunction

   function automatic logic [127:0] aes_block(input logic [127:0] din);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [127:0] st;
      st = din ^ sched_key[0];
      for (int r = 1; r <= 10; r++) begin
         for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
         for (int i = 0; i < 16; i++) t[i] = sub_table[s[(i + 4*(i & 3)) & 15]];
         if (r < 10) begin
            for (int c = 0; c < 16; c += 4) begin
               s[c]   = dbl8(t[c]) ^ dbl8(t[c+1]) ^ t[c+1] ^ t[c+2] ^ t[c+3];
               s[c+1] = t[c] ^ dbl8(t[c+1]) ^ dbl8(t[c+2]) ^ t[c+2] ^ t[c+3];
               s[c+2] = t[c] ^ t[c+1] ^ dbl8(t[c+2]) ^ dbl8(t[c+3]) ^ t[c+3];
               s[c+3] = dbl8(t[c]) ^ t[c] ^ t[c+1] ^ t[c+2] ^ dbl8(t[c+3]);
            end
         end else begin
            s = t;
         end
         for (int i = 0; i < 16; i++) st[127-8*i -: 8] = s[i];
         st ^= sched_key[r];
      end
      return st;
   endfunction

   // GHASH step: acc = (acc ^ x) * H in GF(2^128), bit-reflected order.
   function automatic void hash_absorb(input logic [127:0] blk);
      logic [127:0] x;
      logic [127:0] v;
      logic [127:0] z;
      logic lsb;
      x = hash_acc ^ blk;
      v = hash_key;
      z = '0;
      for (int i = 0; i < 128; i++) begin
         if (x[127-i]) z ^= v;
         lsb = v[0];
         v = v >> 1;
         if (lsb) v[127:120] ^= 8'he1;
      end
      hash_acc = z;
   endfunction

   function automatic logic [127:0] lead_bytes(input int n);
      logic [127:0] m;
      for (int i = 0; i < 16; i++) m[127-8*i -: 8] = (i < n) ? 8'hff : 8'h00;
      return m;
   endfunction

   // Tag that a finish item would give now, without changing the state.
   function automatic logic [127:0] tag_now();
      logic [127:0] saved;
      logic [127:0] tag;
      saved = hash_acc;
      hash_absorb({32'h0, 32'(aad_total) << 3, 32'h0, 32'(text_total) << 3});
      tag = hash_acc ^ tag_mask;
      hash_acc = saved;
      return tag;
   endfunction

   // Works out the response of one accepted item and advances the state.
   function automatic bit gcm_process_item(input logic [1:0] kind, input logic [127:0] blk,
                                           input logic [4:0] cnt,
                                           output gcm_result_type res);
      int n;
      logic [127:0] m;
      logic [127:0] ks;
      logic [127:0] ct;
      logic [127:0] tag;
      n = (cnt > 16) ? 16 : int'(cnt);
      res = '0;
      if (kind == agcm_pkg::REQ_NONE) return 0;
      if (kind == agcm_pkg::REQ_AAD && phase == agcm_pkg::PHASE_TEXT) begin
         res.order_error = 1'b1;
         return 1;
      end
      // A new message derives H and E(J0) and clears the running values.
      if (phase == agcm_pkg::PHASE_FRESH) begin
         expand_cipher_key();
         hash_key = aes_block('0);
         tag_mask = aes_block({iv_high, iv_low, 32'h1});
         hash_acc = '0;
         counter = 32'd2;
         aad_total = '0;
         text_total = '0;
         phase = agcm_pkg::PHASE_AAD;
      end
      m = lead_bytes(n);
      if (kind == agcm_pkg::REQ_AAD) begin
         if (n != 0) begin
            hash_absorb(blk & m);
            aad_total += 29'(n);
         end
         return 0;
      end
      if (kind == agcm_pkg::REQ_TEXT) begin
         phase = agcm_pkg::PHASE_TEXT;
         if (n != 0) begin
            ks = aes_block({iv_high, iv_low, counter});
            ct = (blk ^ ks) & m;
            hash_absorb(decrypt_on ? (blk & m) : ct);
            counter += 32'd1;
            text_total += 29'(n);
            {res.out_high, res.out_low} = ct;
            res.out_count = 5'(n);
         end
         return 1;
      end
      tag = tag_now();
      res.is_final = 1'b1;
      if (decrypt_on) begin
         res.tag_match = (tag == blk);
      end else begin
         {res.out_high, res.out_low} = tag;
         res.out_count = 5'd16;
      end
      phase = agcm_pkg::PHASE_FRESH;
      return 1;
   endfunction

   // Waits until every response is in and the core has gone quiet.
   task automatic wait_idle();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write; the sender is idle whenever this runs.
   task automatic write_csr(input logic [agcm_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [63:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         agcm_pkg::CSR_KEY_HIGH:     cipher_key[127:64] = data;
         agcm_pkg::CSR_KEY_LOW:      cipher_key[63:0] = data;
         agcm_pkg::CSR_NONCE_HIGH:   iv_high = data;
         agcm_pkg::CSR_NONCE_LOW:    iv_low = data[31:0];
         agcm_pkg::CSR_DECRYPT_MODE: decrypt_on = data[0];
         default: ;
      endcase
   endtask

   // Offers one item after a random gap and records its response on acceptance.
   task automatic send_item(input logic [1:0] kind, input logic [127:0] blk,
                            input logic [4:0] cnt, input bit typed,
                            input gcm_result_type typed_result);
      int gap;
      gcm_result_type res;
      bit has_res;
      gap = quiet_sender ? 0 : $urandom_range(0, 13);
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
      end
      @(negedge clock);
      req_chan.valid = 1'b1;
      req_chan.req_type = kind;
      {req_chan.block_high, req_chan.block_low} = blk;
      req_chan.byte_count = cnt;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      has_res = gcm_process_item(kind, blk, cnt, res);
      if (typed) begin
         has_res = typed_result.is_final || typed_result.order_error
                   || kind == agcm_pkg::REQ_TEXT;
         res = typed_result;
      end
      if (has_res) pending_results.push_back(res);
      items_sent++;
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   function automatic logic [4:0] random_count();
      case ($urandom_range(0, 9))
         0:       return 5'($urandom_range(0, 31));
         1, 2:    return 5'($urandom_range(1, 15));
         default: return 5'd16;
      endcase
   endfunction

   function automatic logic [63:0] random_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Response side: random ready, one long hold-off, in-order checking.
   initial begin
      gcm_result_type got;
      gcm_result_type want;
      int stall;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (results_seen == 150) begin
            rsp_chan.ready = 1'b0;
            repeat (600) @(negedge clock);
         end
         if (results_seen % 60 == 0) quiet_receiver = ($urandom_range(0, 2) == 0);
         stall = quiet_receiver ? 0 : $urandom_range(0, 13);
         repeat (stall) begin
            rsp_chan.ready = 1'b0;
            @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got = '{rsp_chan.out_high, rsp_chan.out_low, rsp_chan.out_count,
                 rsp_chan.is_final, rsp_chan.tag_match, rsp_chan.order_error};
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response %p", $realtime, got);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.out_high !== want.out_high || got.out_low !== want.out_low
                || got.out_count !== want.out_count || got.is_final !== want.is_final
                || got.tag_match !== want.tag_match
                || got.order_error !== want.order_error) begin
               $display("%0t: response mismatch, expected %p, actual %p",
                        $realtime, want, got);
               error_count++;
            end
         end
         @(negedge clock);
      end
   end

   // Stimulus.
   initial begin
      directed_row_type rows [$];
      gcm_result_type none;
      gcm_result_type zero_text;
      gcm_result_type order_flag;
      gcm_result_type bad_tag;
      logic [127:0] blk;
      int n_aad;
      int n_text;
      bit broken;

      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = agcm_pkg::CSR_KEY_HIGH;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.req_type = agcm_pkg::REQ_AAD;
      req_chan.block_high = '0;
      req_chan.block_low = '0;
      req_chan.byte_count = '0;
      error_count = 0;
      cycle_count = 0;
      items_sent = 0;
      results_seen = 0;
      quiet_sender = 1'b0;
      quiet_receiver = 1'b0;
      build_sub_table();
      cipher_key = '0;
      iv_high = '0;
      iv_low = '0;
      decrypt_on = 1'b0;
      hash_key = '0;
      tag_mask = '0;
      hash_acc = '0;
      counter = 32'd2;
      aad_total = '0;
      text_total = '0;
      phase = agcm_pkg::PHASE_FRESH;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      none = '0;
      zero_text = '0;
      order_flag = '0;
      order_flag.order_error = 1'b1;
      bad_tag = '0;
      bad_tag.is_final = 1'b1;

      // Directed items under the reset configuration, then in decrypt mode.
      rows = '{
         '{agcm_pkg::REQ_AAD,    '1, '1, 5'd16, 0, 0, 0, none},
         '{agcm_pkg::REQ_AAD,    '1, '1, 5'd0,  0, 0, 0, none},
         '{agcm_pkg::REQ_AAD,    '1, '0, 5'd31, 0, 0, 0, none},
         '{agcm_pkg::REQ_NONE,   '1, '1, 5'd16, 0, 0, 0, none},
         '{agcm_pkg::REQ_TEXT,   '1, '1, 5'd16, 0, 0, 0, none},
         '{agcm_pkg::REQ_TEXT,   '1, '1, 5'd0,  0, 0, 1, zero_text},
         '{agcm_pkg::REQ_TEXT,   '1, '1, 5'd1,  0, 0, 0, none},
         '{agcm_pkg::REQ_TEXT,   '0, '1, 5'd9,  0, 0, 0, none},
         '{agcm_pkg::REQ_TEXT,   '1, '1, 5'd20, 0, 0, 0, none},
         '{agcm_pkg::REQ_AAD,    '1, '1, 5'd16, 0, 0, 1, order_flag},
         '{agcm_pkg::REQ_FINISH, '0, '0, 5'd0,  0, 0, 0, none},
         '{agcm_pkg::REQ_FINISH, '1, '1, 5'd31, 0, 0, 0, none},
         '{agcm_pkg::REQ_TEXT,   '0, '0, 5'd16, 0, 0, 0, none},
         '{agcm_pkg::REQ_FINISH, '0, '0, 5'd16, 0, 0, 0, none},
         '{agcm_pkg::REQ_AAD,    '0, '0, 5'd16, 1, 0, 0, none},
         '{agcm_pkg::REQ_TEXT,   '1, '1, 5'd15, 0, 0, 0, none},
         '{agcm_pkg::REQ_TEXT,   '1, '1, 5'd16, 0, 0, 0, none},
         '{agcm_pkg::REQ_FINISH, '0, '0, 5'd0,  0, 1, 0, none},
         '{agcm_pkg::REQ_TEXT,   '0, '1, 5'd8,  0, 0, 0, none},
         '{agcm_pkg::REQ_FINISH, '1, '1, 5'd0,  0, 0, 1, bad_tag}
      };
      foreach (rows[i]) begin
         if (rows[i].set_decrypt) begin
            drop_valid();
            wait_idle();
            write_csr(agcm_pkg::CSR_DECRYPT_MODE, 64'd1);
         end
         blk = {rows[i].block_high, rows[i].block_low};
         if (rows[i].good_tag) blk = tag_now();
         send_item(rows[i].kind, blk, rows[i].byte_count, rows[i].typed, rows[i].typed_result);
      end
      drop_valid();

      // Extreme settings first, then random ones between messages.
      wait_idle();
      write_csr(agcm_pkg::CSR_KEY_HIGH, '1);
      write_csr(agcm_pkg::CSR_KEY_LOW, '1);
      write_csr(agcm_pkg::CSR_NONCE_HIGH, '1);
      write_csr(agcm_pkg::CSR_NONCE_LOW, 64'hffff_ffff);
      write_csr(agcm_pkg::CSR_DECRYPT_MODE, 64'd0);

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 3) == 0) begin
            drop_valid();
            wait_idle();
            write_csr(agcm_pkg::CSR_KEY_HIGH, random_word());
            write_csr(agcm_pkg::CSR_KEY_LOW, random_word());
            write_csr(agcm_pkg::CSR_NONCE_HIGH, random_word());
            write_csr(agcm_pkg::CSR_NONCE_LOW, random_word() >> 32);
            write_csr(agcm_pkg::CSR_DECRYPT_MODE, 64'($urandom_range(0, 1)));
         end
         quiet_sender = ($urandom_range(0, 3) == 0);
         broken = ($urandom_range(0, 7) == 0);
         n_aad = $urandom_range(0, 4);
         n_text = $urandom_range(0, 6);
         // A message: AAD, then text, then finish, well-formed unless broken.
         for (int i = 0; i < n_aad; i++)
            send_item(agcm_pkg::REQ_AAD, {random_word(), random_word()}, random_count(),
                      0, none);
         for (int i = 0; i < n_text; i++) begin
            send_item(agcm_pkg::REQ_TEXT, {random_word(), random_word()}, random_count(),
                      0, none);
            // Noise: unknown items and AAD out of order.
            if (broken && $urandom_range(0, 2) == 0)
               send_item(2'($urandom_range(0, 1) ? agcm_pkg::REQ_NONE : agcm_pkg::REQ_AAD),
                         {random_word(), random_word()}, random_count(), 0, none);
         end
         blk = (decrypt_on && $urandom_range(0, 1)) ? tag_now()
               : {random_word(), random_word()};
         send_item(agcm_pkg::REQ_FINISH, blk, 5'($urandom_range(0, 31)), 0, none);
      end
      drop_valid();

      wait_idle();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/agcm_pkg.sv
src/agcm_channels.sv
src/agcm_aes_core.sv
src/agcm_ghash.sv
src/agcm_datapath.sv
src/agcm_ctrl.sv
src/aes128_gcm_stream_core.sv
tb/testbench.sv
